// File: design/ilir_pkg.sv
// shared types and codes for the indexed list block
// no dependencies; used by ilir_seq and indexed_list_insert_remove
package ilir_pkg;

    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_INSERT = 3'd1;
    localparam logic [2:0] MODE_REMOVE = 3'd2;
    localparam logic [2:0] MODE_READ   = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    localparam int MODE_BITS  = 3;
    localparam int POS_BITS   = 6;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 5;
    localparam int IN_BYTES   = 6;
    localparam int OUT_BYTES  = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UP,
        ST_PUT,
        ST_DOWN
    } state_t;

    typedef struct packed {
        logic                    valid;
        logic [VALUE_BITS-1:0]   read_value;
        logic [COUNT_BITS-1:0]   count;
        logic                    status;
    } result_t;

endpackage

// File: design/ilir_ram.sv
// entry storage: one write port, one read port, registered read data
// no dependencies
module ilir_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/ilir_seq.sv
// request sequencer: decodes a list operation, keeps the entry count and
// walks the entry ram to shift entries; uses ilir_pkg
module ilir_seq #(
    parameter int CAPACITY = 16,
    parameter int MEM_W    = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        req_fire,
    input  logic [ilir_pkg::MODE_BITS-1:0]  req_mode,
    input  logic signed [ilir_pkg::POS_BITS-1:0] req_position,
    input  logic [ilir_pkg::VALUE_BITS-1:0] req_value,
    output logic                        idle,
    output logic                        ram_we,
    output logic [$clog2(CAPACITY)-1:0] ram_waddr,
    output logic [MEM_W-1:0]            ram_wdata,
    output logic [$clog2(CAPACITY)-1:0] ram_raddr,
    input  logic [MEM_W-1:0]            ram_rdata,
    output ilir_pkg::result_t           res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > ilir_pkg::POS_BITS) ? CW : ilir_pkg::POS_BITS) + 2;

    ilir_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [MEM_W-1:0] val_reg, val_next;
    logic [MEM_W-1:0] rd_reg, rd_next;
    logic             remove_reg, remove_next;

    logic signed [PW-1:0] pos_s;
    logic signed [PW-1:0] n_s;
    logic signed [PW-1:0] adj_s;
    logic                 full;
    logic [AW-1:0]        last_idx;

    assign pos_s    = PW'(req_position);
    assign n_s      = $signed(PW'(count_reg));
    assign adj_s    = (pos_s < 0) ? (pos_s + n_s) : pos_s;
    assign full     = (count_reg == CW'(CAPACITY));
    assign last_idx = AW'(count_reg - 1'b1);
    assign idle     = (state_reg == ilir_pkg::ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ilir_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        addr_reg   <= addr_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        rd_reg     <= rd_next;
        remove_reg <= remove_next;
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        rd_next     = rd_reg;
        remove_next = remove_reg;
        ram_we      = 1'b0;
        ram_waddr   = addr_reg;
        ram_wdata   = val_reg;
        ram_raddr   = addr_reg;
        res         = '0;

        unique case (state_reg)
            ilir_pkg::ST_IDLE: begin
                if (req_fire) begin
                    val_next    = MEM_W'(req_value);
                    pos_next    = AW'(pos_s);
                    remove_next = (req_mode == ilir_pkg::MODE_REMOVE);
                    res.valid   = 1'b1;
                    res.count   = ilir_pkg::COUNT_BITS'(count_reg);
                    res.status  = 1'b1;
                    unique case (req_mode) inside
                        ilir_pkg::MODE_APPEND: begin
                            if (!full) begin
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(count_reg);
                                ram_wdata  = MEM_W'(req_value);
                                count_next = CW'(count_reg + 1'b1);
                                res.count  = ilir_pkg::COUNT_BITS'(count_next);
                                res.status = 1'b0;
                            end
                        end
                        ilir_pkg::MODE_INSERT: begin
                            if (!full && pos_s >= 0 && pos_s <= n_s) begin
                                if (pos_s == n_s) begin
                                    // insert at the end needs no shift
                                    ram_we     = 1'b1;
                                    ram_waddr  = AW'(count_reg);
                                    ram_wdata  = MEM_W'(req_value);
                                    count_next = CW'(count_reg + 1'b1);
                                    res.count  = ilir_pkg::COUNT_BITS'(count_next);
                                    res.status = 1'b0;
                                end else begin
                                    ram_raddr  = last_idx;
                                    addr_next  = last_idx;
                                    state_next = ilir_pkg::ST_UP;
                                    res.valid  = 1'b0;
                                end
                            end
                        end
                        ilir_pkg::MODE_REMOVE, ilir_pkg::MODE_READ: begin
                            if (adj_s >= 0 && adj_s < n_s) begin
                                ram_raddr  = AW'(adj_s);
                                addr_next  = AW'(adj_s);
                                state_next = ilir_pkg::ST_READ;
                                res.valid  = 1'b0;
                            end
                        end
                        ilir_pkg::MODE_CLEAR: begin
                            count_next = '0;
                            res.count  = '0;
                            res.status = 1'b0;
                        end
                        default: begin
                            res.status = 1'b1;
                        end
                    endcase
                end
            end
            ilir_pkg::ST_READ: begin
                rd_next = ram_rdata;
                if (!remove_reg) begin
                    res.valid      = 1'b1;
                    res.read_value = ilir_pkg::VALUE_BITS'(ram_rdata);
                    res.count      = ilir_pkg::COUNT_BITS'(count_reg);
                    state_next     = ilir_pkg::ST_IDLE;
                end else if (addr_reg == last_idx) begin
                    count_next     = CW'(count_reg - 1'b1);
                    res.valid      = 1'b1;
                    res.read_value = ilir_pkg::VALUE_BITS'(ram_rdata);
                    res.count      = ilir_pkg::COUNT_BITS'(count_next);
                    state_next     = ilir_pkg::ST_IDLE;
                end else begin
                    ram_raddr  = AW'(addr_reg + 1'b1);
                    addr_next  = AW'(addr_reg + 1'b1);
                    state_next = ilir_pkg::ST_DOWN;
                end
            end
            ilir_pkg::ST_DOWN: begin
                // data of addr_reg moves one place down
                ram_we    = 1'b1;
                ram_waddr = AW'(addr_reg - 1'b1);
                ram_wdata = ram_rdata;
                if (addr_reg == last_idx) begin
                    count_next     = CW'(count_reg - 1'b1);
                    res.valid      = 1'b1;
                    res.read_value = ilir_pkg::VALUE_BITS'(rd_reg);
                    res.count      = ilir_pkg::COUNT_BITS'(count_next);
                    state_next     = ilir_pkg::ST_IDLE;
                end else begin
                    ram_raddr = AW'(addr_reg + 1'b1);
                    addr_next = AW'(addr_reg + 1'b1);
                end
            end
            ilir_pkg::ST_UP: begin
                // data of addr_reg moves one place up
                ram_we    = 1'b1;
                ram_waddr = AW'(addr_reg + 1'b1);
                ram_wdata = ram_rdata;
                if (addr_reg == pos_reg) begin
                    state_next = ilir_pkg::ST_PUT;
                end else begin
                    ram_raddr = AW'(addr_reg - 1'b1);
                    addr_next = AW'(addr_reg - 1'b1);
                end
            end
            ilir_pkg::ST_PUT: begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = val_reg;
                count_next = CW'(count_reg + 1'b1);
                res.valid  = 1'b1;
                res.count  = ilir_pkg::COUNT_BITS'(count_next);
                state_next = ilir_pkg::ST_IDLE;
            end
            default: begin
                state_next = ilir_pkg::ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |=> state_reg == ilir_pkg::ST_IDLE)
        else $error("sequencer busy after result");

    a_up_above_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ilir_pkg::ST_UP |-> addr_reg >= pos_reg)
        else $error("shift up walked below insert position");

    a_down_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ilir_pkg::ST_DOWN |-> addr_reg <= last_idx && count_reg != '0)
        else $error("shift down walked past last entry");

endmodule

// File: design/indexed_list_insert_remove.sv
// append, clear, flagged requests and insert at p = n finish in ST_IDLE; a read ends in
// ST_READ; remove at p moves p+1..n-1 down, insert at p < n moves n-1..p up and then
// writes at p (n = entry count); one request at a time: the single ram read and write
// port carries every shift step, so the next request is taken only in ST_IDLE; a result
// waiting in the output register holds off the next request until it is taken
// reset (aresetn low, synchronous) empties the list; entry contents stay unknown
// top level of the indexed list; uses ilir_pkg, ilir_seq and ilir_ram
module indexed_list_insert_remove #(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] mode, [8:3] position, [40:9] value, [47:41] zero
    input  logic [8*ilir_pkg::IN_BYTES-1:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] read_value, [36:32] count, [37] status, [39:38] zero
    output logic [8*ilir_pkg::OUT_BYTES-1:0] m_axis_tdata
);

    localparam int MEM_W = (WORD_BITS < ilir_pkg::VALUE_BITS) ? WORD_BITS
                                                              : ilir_pkg::VALUE_BITS;
    localparam int AW    = $clog2(CAPACITY);

    logic                  seq_idle;
    logic                  req_fire;
    ilir_pkg::result_t     res;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [MEM_W-1:0]      ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [MEM_W-1:0]      ram_rdata;

    logic                  out_valid_reg, out_valid_next;
    ilir_pkg::result_t     out_reg, out_next;

    logic [ilir_pkg::MODE_BITS-1:0]         in_mode;
    logic signed [ilir_pkg::POS_BITS-1:0]   in_position;
    logic [ilir_pkg::VALUE_BITS-1:0]        in_value;

    assign in_mode     = s_axis_tdata[2:0];
    assign in_position = s_axis_tdata[8:3];
    assign in_value    = s_axis_tdata[40:9];

    assign s_axis_tready = seq_idle && (!out_valid_reg || m_axis_tready);
    assign req_fire      = s_axis_tvalid && s_axis_tready;

    ilir_seq #(
        .CAPACITY (CAPACITY),
        .MEM_W    (MEM_W)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_fire     (req_fire),
        .req_mode     (in_mode),
        .req_position (in_position),
        .req_value    (in_value),
        .idle         (seq_idle),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .res          (res)
    );

    ilir_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (MEM_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (res.valid) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg.status, out_reg.count, out_reg.read_value};

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> (!out_valid_reg || m_axis_tready))
        else $error("result overwrote a waiting result");

endmodule
